// File: src/instrument_status_reporting_core_macros.svh
// Assertion helpers shared by the status reporting core.
`ifndef INSTRUMENT_STATUS_REPORTING_CORE_MACROS_SVH
`define INSTRUMENT_STATUS_REPORTING_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ISR_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ISR_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/isr_pkg.sv
package isr_pkg;

    localparam int unsigned GROUP_W = 16;
    localparam int unsigned BYTE_W  = 8;

    // Command codes carried on s_tuser
    typedef enum logic [3:0] {
        OP_OPER_SET   = 4'd0,
        OP_OPER_CLEAR = 4'd1,
        OP_OPER_READ  = 4'd2,
        OP_QUES_SET   = 4'd3,
        OP_QUES_CLEAR = 4'd4,
        OP_QUES_READ  = 4'd5,
        OP_SESR_SET   = 4'd6,
        OP_SESR_READ  = 4'd7,
        OP_STB_READ   = 4'd8
    } op_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_OPER_ENABLE     = 3'd0,
        REG_OPER_POS_FILTER = 3'd1,
        REG_OPER_NEG_FILTER = 3'd2,
        REG_QUES_ENABLE     = 3'd3,
        REG_QUES_POS_FILTER = 3'd4,
        REG_QUES_NEG_FILTER = 3'd5,
        REG_SESR_ENABLE     = 3'd6,
        REG_SRQ_ENABLE      = 3'd7
    } reg_idx_t;

    // Status byte bit positions
    localparam int unsigned STB_EAV_BIT  = 2;
    localparam int unsigned STB_QUES_BIT = 3;
    localparam int unsigned STB_ESB_BIT  = 5;
    localparam int unsigned STB_RQS_BIT  = 6;
    localparam int unsigned STB_OPER_BIT = 7;

    typedef struct packed {
        logic [GROUP_W-1:0] oper_enable;
        logic [GROUP_W-1:0] oper_pos_filter;
        logic [GROUP_W-1:0] oper_neg_filter;
        logic [GROUP_W-1:0] ques_enable;
        logic [GROUP_W-1:0] ques_pos_filter;
        logic [GROUP_W-1:0] ques_neg_filter;
        logic [BYTE_W-1:0]  sesr_enable;
        logic [BYTE_W-1:0]  srq_enable;
    } cfg_t;

endpackage

// File: src/isr_cfg.sv
module isr_cfg (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       wr_en,
    input  logic [2:0]                 wr_index,
    input  logic [isr_pkg::GROUP_W-1:0] wr_data,
    output isr_pkg::cfg_t              cfg
);

    isr_pkg::cfg_t cfg_reg;
    isr_pkg::cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (isr_pkg::reg_idx_t'(wr_index))
                isr_pkg::REG_OPER_ENABLE:     cfg_next.oper_enable     = wr_data;
                isr_pkg::REG_OPER_POS_FILTER: cfg_next.oper_pos_filter = wr_data;
                isr_pkg::REG_OPER_NEG_FILTER: cfg_next.oper_neg_filter = wr_data;
                isr_pkg::REG_QUES_ENABLE:     cfg_next.ques_enable     = wr_data;
                isr_pkg::REG_QUES_POS_FILTER: cfg_next.ques_pos_filter = wr_data;
                isr_pkg::REG_QUES_NEG_FILTER: cfg_next.ques_neg_filter = wr_data;
                isr_pkg::REG_SESR_ENABLE:
                    cfg_next.sesr_enable = wr_data[isr_pkg::BYTE_W-1:0];
                isr_pkg::REG_SRQ_ENABLE:
                    cfg_next.srq_enable = wr_data[isr_pkg::BYTE_W-1:0];
                default: cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: src/isr_status.sv
`include "instrument_status_reporting_core_macros.svh"

module isr_status (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        fire,
    input  isr_pkg::op_t                op,
    input  logic [isr_pkg::GROUP_W-1:0] bits,
    input  logic                        err_queue_nonempty,
    input  isr_pkg::cfg_t               cfg,
    output logic [isr_pkg::GROUP_W-1:0] read_data
);

    logic [isr_pkg::GROUP_W-1:0] oper_condition_reg, oper_condition_next;
    logic [isr_pkg::GROUP_W-1:0] oper_event_reg, oper_event_next;
    logic [isr_pkg::GROUP_W-1:0] ques_condition_reg, ques_condition_next;
    logic [isr_pkg::GROUP_W-1:0] ques_event_reg, ques_event_next;
    logic [isr_pkg::BYTE_W-1:0]  std_event_reg, std_event_next;
    logic [isr_pkg::BYTE_W-1:0]  summary;
    logic [isr_pkg::BYTE_W-1:0]  masked_summary;

    // Summary byte, then the SRQ-masked byte with the request bit added
    always_comb begin
        summary = '0;
        summary[isr_pkg::STB_OPER_BIT] = |(oper_event_reg & cfg.oper_enable);
        summary[isr_pkg::STB_QUES_BIT] = |(ques_event_reg & cfg.ques_enable);
        summary[isr_pkg::STB_ESB_BIT]  = |(std_event_reg & cfg.sesr_enable);
        summary[isr_pkg::STB_EAV_BIT]  = err_queue_nonempty;
        masked_summary = summary & cfg.srq_enable;
        masked_summary[isr_pkg::STB_RQS_BIT] = |masked_summary;
    end

    always_comb begin
        oper_condition_next = oper_condition_reg;
        oper_event_next     = oper_event_reg;
        ques_condition_next = ques_condition_reg;
        ques_event_next     = ques_event_reg;
        std_event_next      = std_event_reg;
        read_data           = '0;
        case (op)
            isr_pkg::OP_OPER_SET: begin
                oper_condition_next = oper_condition_reg | bits;
                oper_event_next = oper_event_reg
                    | (bits & ~oper_condition_reg & cfg.oper_pos_filter);
            end
            isr_pkg::OP_OPER_CLEAR: begin
                oper_condition_next = oper_condition_reg & ~bits;
                oper_event_next = oper_event_reg
                    | (bits & oper_condition_reg & cfg.oper_neg_filter);
            end
            isr_pkg::OP_OPER_READ: begin
                read_data       = oper_event_reg & cfg.oper_enable;
                oper_event_next = '0;
            end
            isr_pkg::OP_QUES_SET: begin
                ques_condition_next = ques_condition_reg | bits;
                ques_event_next = ques_event_reg
                    | (bits & ~ques_condition_reg & cfg.ques_pos_filter);
            end
            isr_pkg::OP_QUES_CLEAR: begin
                ques_condition_next = ques_condition_reg & ~bits;
                ques_event_next = ques_event_reg
                    | (bits & ques_condition_reg & cfg.ques_neg_filter);
            end
            isr_pkg::OP_QUES_READ: begin
                read_data       = ques_event_reg & cfg.ques_enable;
                ques_event_next = '0;
            end
            isr_pkg::OP_SESR_SET: begin
                std_event_next = std_event_reg | bits[isr_pkg::BYTE_W-1:0];
            end
            isr_pkg::OP_SESR_READ: begin
                read_data      = {{(isr_pkg::GROUP_W-isr_pkg::BYTE_W){1'b0}},
                                  std_event_reg & cfg.sesr_enable};
                std_event_next = '0;
            end
            isr_pkg::OP_STB_READ: begin
                read_data = {{(isr_pkg::GROUP_W-isr_pkg::BYTE_W){1'b0}}, masked_summary};
            end
            default: read_data = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oper_condition_reg <= '0;
            oper_event_reg     <= '0;
            ques_condition_reg <= '0;
            ques_event_reg     <= '0;
            std_event_reg      <= '0;
        end else if (fire) begin
            oper_condition_reg <= oper_condition_next;
            oper_event_reg     <= oper_event_next;
            ques_condition_reg <= ques_condition_next;
            ques_event_reg     <= ques_event_next;
            std_event_reg      <= std_event_next;
        end
    end

    `ISR_ASSERT_NEXT(a_oper_read_clears, aclk, aresetn, fire && op == isr_pkg::OP_OPER_READ, oper_event_reg == '0, "oper event read did not clear")
    `ISR_ASSERT_NEXT(a_sesr_read_clears, aclk, aresetn, fire && op == isr_pkg::OP_SESR_READ, std_event_reg == '0, "sesr read did not clear")
    `ISR_ASSERT_NEXT(a_idle_holds_cond, aclk, aresetn, !fire, $stable(oper_condition_reg) && $stable(ques_condition_reg), "condition moved without a command")

endmodule

// File: src/instrument_status_reporting_core.sv
//  Channel   Dir  Handshake            Payload
//  s_        in   s_tvalid/s_tready    s_tuser = op, s_tdata = bits, error_queue_nonempty
//  m_        out  m_tvalid/m_tready    m_tdata = read_data
//  cfg_      in   cfg_valid/cfg_ready  cfg_index, cfg_data
//
//  One word in, one word out; sustained rate is one word per cycle while m_tready stays high.
//  Each word passes through the input register, then the status update and result register.
//  The status registers advance only when the held word moves into the result register.
//  s_tready drops only when both the input and result registers are full and m_tready is low.
//  aresetn is synchronous, active low; it clears all status and config registers.
//  cfg_ready is always high; a write takes effect in the cycle after it is accepted.
`include "instrument_status_reporting_core_macros.svh"

module instrument_status_reporting_core (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [23:0]                 s_tdata,   // [15:0] bits, [16] error_queue_nonempty, rest zero
    input  logic [3:0]                  s_tuser,   // [3:0] op

    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [isr_pkg::GROUP_W-1:0] m_tdata,   // [15:0] read_data

    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [2:0]                  cfg_index,
    input  logic [isr_pkg::GROUP_W-1:0] cfg_data
);

    // Input word register
    logic                        in_vld_reg;
    isr_pkg::op_t                in_op_reg;
    logic [isr_pkg::GROUP_W-1:0] in_bits_reg;
    logic                        in_eq_reg;

    // Result register
    logic                        out_vld_reg;
    logic [isr_pkg::GROUP_W-1:0] out_data_reg;

    logic                        out_free;
    logic                        advance;
    logic                        s_fire;
    logic [isr_pkg::GROUP_W-1:0] read_data;
    isr_pkg::cfg_t               cfg;

    assign out_free = !out_vld_reg || m_tready;
    assign advance  = in_vld_reg && out_free;
    assign s_tready = !in_vld_reg || out_free;
    assign s_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    isr_cfg u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    isr_status u_status (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .fire               (advance),
        .op                 (in_op_reg),
        .bits               (in_bits_reg),
        .err_queue_nonempty (in_eq_reg),
        .cfg                (cfg),
        .read_data          (read_data)
    );

    // Valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                in_vld_reg <= 1'b1;
            end else if (advance) begin
                in_vld_reg <= 1'b0;
            end
            if (advance) begin
                out_vld_reg <= 1'b1;
            end else if (m_tready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Payload, no reset needed
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_op_reg   <= isr_pkg::op_t'(s_tuser);
            in_bits_reg <= s_tdata[isr_pkg::GROUP_W-1:0];
            in_eq_reg   <= s_tdata[isr_pkg::GROUP_W];
        end
        if (advance) begin
            out_data_reg <= read_data;
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    `ISR_ASSERT_NOW(a_empty_ready, aclk, aresetn, !in_vld_reg, s_tready, "empty input register not ready")
    `ISR_ASSERT_NEXT(a_held_word_kept, aclk, aresetn, in_vld_reg && !out_free, in_vld_reg, "held word dropped")
    `ISR_ASSERT_NEXT(a_advance_shows, aclk, aresetn, advance, m_tvalid, "result not presented")

endmodule
